FILE: src/bledch_pkg.sv
// ----------------------------------------------------------------------------
// bledch_pkg
// Shared constants and types of the data-channel hopper.
// ----------------------------------------------------------------------------
package bledch_pkg;

  // Default number of data channels and the fixed field widths
  localparam int NumDataChannels = 37;
  localparam int MapW            = 37;
  localparam int OpW             = 2;
  localparam int InstW           = 16;
  localparam int ChanW           = 6;
  localparam int FreqW           = 7;
  localparam int HopIncW         = 5;

  // Operation codes
  localparam logic [OpW-1:0] OpStart  = 2'd0;
  localparam logic [OpW-1:0] OpEvent  = 2'd1;
  localparam logic [OpW-1:0] OpUpdate = 2'd2;

  localparam logic [HopIncW-1:0] HopIncReset   = 5'd5;
  localparam logic [InstW-1:0]   InstantWindow = 16'd32767;
  localparam logic [InstW-1:0]   InstantReset  = 16'hFFFF;
  localparam logic [ChanW-1:0]   LowBandLast   = 6'd10;
  localparam logic [FreqW-1:0]   FreqLowBase   = 7'd4;
  localparam logic [FreqW-1:0]   FreqHighBase  = 7'd6;

  // Remainder unit: operands up to 2*64 - 1
  localparam int DivW    = 7;
  localparam int DivCntW = 3;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } mod_rsp_t;

endpackage

FILE: src/bledch_mod.sv
// ----------------------------------------------------------------------------
// bledch_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bledch_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bledch_pkg::mod_req_t req_i,
  output bledch_pkg::mod_rsp_t rsp_o
);

  logic [bledch_pkg::DivW-1:0]    dvd_q;
  logic [bledch_pkg::DivW-1:0]    dsr_q;
  logic [bledch_pkg::DivW-1:0]    rem_q;
  logic [bledch_pkg::DivCntW-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [bledch_pkg::DivW-1:0]    trial;

  // remainder stays below the divisor (at most 64), so one shift fits
  assign trial = {rem_q[bledch_pkg::DivW-2:0], dvd_q[bledch_pkg::DivW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == bledch_pkg::DivCntW'(bledch_pkg::DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[bledch_pkg::DivW-2:0], 1'b0};
      rem_q <= (trial >= dsr_q) ? trial - dsr_q : trial;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: src/bledch_remap_ram.sv
// ----------------------------------------------------------------------------
// bledch_remap_ram
// Remap table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bledch_remap_ram #(
  parameter int Depth = bledch_pkg::NumDataChannels,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [bledch_pkg::ChanW-1:0] wdata_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [bledch_pkg::ChanW-1:0] rdata_o
);

  logic [bledch_pkg::ChanW-1:0] mem [Depth];
  logic [bledch_pkg::ChanW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ble_data_channel_hopper.sv
// ----------------------------------------------------------------------------
// ble_data_channel_hopper
// Link-layer data-channel hopping, selection algorithm 1.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per command: start,
//   connection event tick or channel map update. Start and the hop half of an
//   event tick give one result beat on the output channel
//   (out_valid_o/out_ready_i); check ticks, updates and code 3 give none.
//   The config channel writes hop_increment and is always ready. The user
//   must see that it is only written while the block is idle; the block
//   does not enforce this.
// Flow:
//   One command at a time. From acceptance to the output register a hop
//   steps the unmapped channel and, when that channel is unused and the map
//   is not empty, runs the remainder unit by the used count, then a remap
//   table read. The step mod NUM_DATA_CHANNELS is a repeated compare and
//   subtract (at most one subtraction at the default 37). A command that
//   loads a map first rebuilds the remap table, one channel per cycle.
// Reset:
//   Empty map, counter 0, no pending update, hop_increment 5. The remap table
//   is not cleared: only entries below the used count are ever read.
// Stall:
//   The result sits in an output register; a new command is taken meanwhile,
//   and a following hop waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module ble_data_channel_hopper #(
  parameter int NUM_DATA_CHANNELS = bledch_pkg::NumDataChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bledch_pkg::HopIncW-1:0] cfg_hop_increment_i,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bledch_pkg::OpW-1:0]     operation_i,
  input  logic [bledch_pkg::MapW-1:0]    channel_map_i,
  input  logic [bledch_pkg::InstW-1:0]   instant_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bledch_pkg::ChanW-1:0]   channel_o,
  output logic [bledch_pkg::FreqW-1:0]   frequency_offset_o,
  output logic [bledch_pkg::InstW-1:0]   event_count_o,
  output logic                           map_empty_o
);

  localparam int N        = NUM_DATA_CHANNELS;
  localparam int IdxW     = $clog2(N);
  localparam int UsedW    = $clog2(N + 1);
  localparam int MapWideW = (N > bledch_pkg::MapW) ? N : bledch_pkg::MapW;
  localparam int MapPadW  = 1 << IdxW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_HOP_START,
    S_HOP_U,
    S_HOP_R,
    S_HOP_RD,
    S_EMIT
  } state_e;

  state_e                          state_q;
  logic [bledch_pkg::HopIncW-1:0]  hop_inc_q;
  logic [IdxW-1:0]                 unmapped_q;
  logic [N-1:0]                    active_map_q;
  logic [UsedW-1:0]                used_q;
  logic [N-1:0]                    pend_map_q;
  logic [bledch_pkg::InstW-1:0]    pend_inst_q;
  logic                            pend_valid_q;
  logic [bledch_pkg::InstW-1:0]    event_cnt_q;
  logic                            check_q;
  logic                            hop_after_q;
  logic [IdxW-1:0]                 build_idx_q;
  logic [bledch_pkg::ChanW-1:0]    ch_q;
  logic                            empty_q;
  logic [bledch_pkg::DivW-1:0]     sum_q;

  logic                            out_valid_q;
  logic [bledch_pkg::ChanW-1:0]    out_ch_q;
  logic [bledch_pkg::FreqW-1:0]    out_freq_q;
  logic [bledch_pkg::InstW-1:0]    out_cnt_q;
  logic                            out_empty_q;

  logic [MapWideW-1:0]             map_wide;
  logic [N-1:0]                    map_in;
  logic [MapPadW-1:0]              map_pad;
  logic [bledch_pkg::InstW-1:0]    inst_diff;
  logic [bledch_pkg::DivW-1:0]     hop_sum;
  logic                            sum_lt_n;
  logic [IdxW-1:0]                 u_idx;
  logic [IdxW-1:0]                 rem_idx;
  logic                            need_remap;
  logic                            out_free;
  logic [bledch_pkg::FreqW-1:0]    freq;
  logic                            ram_we;
  logic [bledch_pkg::ChanW-1:0]    ram_rdata;
  bledch_pkg::mod_req_t            mod_req;
  bledch_pkg::mod_rsp_t            mod_rsp;

  // map bits at or above the channel count are dropped
  assign map_wide  = MapWideW'(channel_map_i);
  assign map_in    = map_wide[N-1:0];
  // map padded to the full index range, so any index reads in bounds
  assign map_pad   = MapPadW'(active_map_q);
  assign inst_diff = instant_i - event_cnt_q;
  assign hop_sum   = bledch_pkg::DivW'(unmapped_q) + bledch_pkg::DivW'(hop_inc_q);
  // step mod N: sum_q is reduced by N per cycle until it drops below N
  assign sum_lt_n  = (sum_q < bledch_pkg::DivW'(N));
  assign u_idx     = sum_q[IdxW-1:0];
  assign rem_idx   = mod_rsp.rem[IdxW-1:0];
  assign need_remap = !map_pad[u_idx] && (used_q != '0);
  assign out_free  = !out_valid_q || out_ready_i;

  // 4 + 2ch in the low band, 6 + 2ch above; wraps to 7 bits
  assign freq = (ch_q <= bledch_pkg::LowBandLast)
              ? {ch_q, 1'b0} + bledch_pkg::FreqLowBase
              : {ch_q, 1'b0} + bledch_pkg::FreqHighBase;

  // Remainder unit only serves u mod used count
  assign mod_req.start    = (state_q == S_HOP_U) && sum_lt_n && need_remap;
  assign mod_req.dividend = sum_q;
  assign mod_req.divisor  = bledch_pkg::DivW'(used_q);

  assign ram_we = (state_q == S_BUILD) && active_map_q[build_idx_q];

  bledch_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  bledch_remap_ram #(
    .Depth (N),
    .AddrW (IdxW)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (used_q[IdxW-1:0]),
    .wdata_i (bledch_pkg::ChanW'(build_idx_q)),
    .raddr_i (rem_idx),
    .rdata_o (ram_rdata)
  );

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_inc_q <= bledch_pkg::HopIncReset;
    end else if (cfg_valid_i) begin
      hop_inc_q <= cfg_hop_increment_i;
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      unmapped_q   <= '0;
      active_map_q <= '0;
      used_q       <= '0;
      pend_map_q   <= '0;
      pend_inst_q  <= bledch_pkg::InstantReset;
      pend_valid_q <= 1'b0;
      event_cnt_q  <= '0;
      check_q      <= 1'b0;
      hop_after_q  <= 1'b0;
      build_idx_q  <= '0;
      ch_q         <= '0;
      empty_q      <= 1'b0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // a result leaving while the next one is loaded stays valid
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            build_idx_q <= '0;
            unique case (operation_i)
              bledch_pkg::OpStart: begin
                active_map_q <= map_in;
                used_q       <= '0;
                unmapped_q   <= '0;
                event_cnt_q  <= '0;
                pend_valid_q <= 1'b0;
                pend_map_q   <= '0;
                pend_inst_q  <= bledch_pkg::InstantReset;
                check_q      <= 1'b0;
                hop_after_q  <= 1'b1;
                state_q      <= S_BUILD;
              end
              bledch_pkg::OpEvent: begin
                if (!check_q) begin
                  event_cnt_q <= event_cnt_q + 1'b1;
                  check_q     <= 1'b1;
                  state_q     <= S_HOP_START;
                end else begin
                  check_q <= 1'b0;
                  if (pend_valid_q && event_cnt_q == pend_inst_q) begin
                    active_map_q <= pend_map_q;
                    used_q       <= '0;
                    pend_valid_q <= 1'b0;
                    hop_after_q  <= 1'b0;
                    state_q      <= S_BUILD;
                  end
                end
              end
              bledch_pkg::OpUpdate: begin
                if (inst_diff < bledch_pkg::InstantWindow) begin
                  pend_map_q   <= map_in;
                  pend_inst_q  <= instant_i;
                  pend_valid_q <= 1'b1;
                end else begin
                  active_map_q <= map_in;
                  used_q       <= '0;
                  pend_valid_q <= 1'b0;
                  hop_after_q  <= 1'b0;
                  state_q      <= S_BUILD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BUILD: begin
          if (active_map_q[build_idx_q]) begin
            used_q <= used_q + 1'b1;
          end
          build_idx_q <= build_idx_q + 1'b1;
          if (build_idx_q == IdxW'(N - 1)) begin
            state_q <= hop_after_q ? S_HOP_START : S_IDLE;
          end
        end
        S_HOP_START: begin
          sum_q   <= hop_sum;
          state_q <= S_HOP_U;
        end
        S_HOP_U: begin
          if (!sum_lt_n) begin
            sum_q <= sum_q - bledch_pkg::DivW'(N);
          end else begin
            unmapped_q <= u_idx;
            if (map_pad[u_idx]) begin
              ch_q    <= bledch_pkg::ChanW'(u_idx);
              empty_q <= 1'b0;
              state_q <= S_EMIT;
            end else if (used_q == '0) begin
              ch_q    <= '0;
              empty_q <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_HOP_R;
            end
          end
        end
        S_HOP_R: begin
          if (mod_rsp.done) begin
            state_q <= S_HOP_RD;
          end
        end
        S_HOP_RD: begin
          ch_q    <= ram_rdata;
          empty_q <= 1'b0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_ch_q    <= ch_q;
      out_freq_q  <= freq;
      out_cnt_q   <= event_cnt_q;
      out_empty_q <= empty_q;
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign channel_o          = out_ch_q;
  assign frequency_offset_o = out_freq_q;
  assign event_count_o      = out_cnt_q;
  assign map_empty_o        = out_empty_q;

  // remainder results only land while a remap waits on them
  a_mod_done_in_hop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_HOP_R))
    else $error("remainder result outside a hop");

  // used count never exceeds the channel count
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(N))
    else $error("used channel count out of range");

  // an empty map always reports channel 0 at the base offset
  a_empty_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && map_empty_o) |->
      (channel_o == '0 && frequency_offset_o == bledch_pkg::FreqLowBase))
    else $error("empty map with non-zero channel");

  // a selected channel is always a real data channel
  a_chan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(channel_o) < N))
    else $error("channel beyond channel count");

endmodule

FILE: test/tb_ble_data_channel_hopper.sv
// ----------------------------------------------------------------------------
// tb_ble_data_channel_hopper
// Self-checking bench for the data-channel hopper (selection algorithm 1).
// A queue-fed driver sends start, event-tick, map-update and unused-code
// beats with random gaps while the result side stalls at random. A predictor
// tracks the hopper's state from accepted beats and every result beat is
// compared field by field with the oldest predicted hop. The hop increment is
// rewritten between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_ble_data_channel_hopper;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused operation code: the block must ignore it
  localparam logic [bledch_pkg::OpW-1:0] OpUnused = 2'd3;

  // Cycles with no handshake on any channel before the run is abandoned.
  // Worst honest case is a long sender gap, a map rebuild plus hop and a long
  // result stall, or the settle pause before a register write: all well under.
  localparam int IdleLimit = 4000;
  // Quiet time after the last result: covers a rebuild plus a hop
  localparam int SettleCycles = 100;

  typedef struct packed {
    logic [bledch_pkg::OpW-1:0]   op;
    logic [bledch_pkg::MapW-1:0]  map;
    logic [bledch_pkg::InstW-1:0] inst;
  } hop_cmd_t;

  typedef struct packed {
    logic [bledch_pkg::ChanW-1:0] channel;
    logic [bledch_pkg::FreqW-1:0] freq;
    logic [bledch_pkg::InstW-1:0] count;
    logic                         empty;
  } hop_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_valid_i         = 1'b0;
  logic                           cfg_ready_o;
  logic [bledch_pkg::HopIncW-1:0] cfg_hop_increment_i = bledch_pkg::HopIncReset;

  logic                           in_valid_i    = 1'b0;
  logic                           in_ready_o;
  logic [bledch_pkg::OpW-1:0]     operation_i   = '0;
  logic [bledch_pkg::MapW-1:0]    channel_map_i = '0;
  logic [bledch_pkg::InstW-1:0]   instant_i     = '0;

  logic                           out_valid_o;
  logic                           out_ready_i   = 1'b0;
  logic [bledch_pkg::ChanW-1:0]   channel_o;
  logic [bledch_pkg::FreqW-1:0]   frequency_offset_o;
  logic [bledch_pkg::InstW-1:0]   event_count_o;
  logic                           map_empty_o;

  ble_data_channel_hopper dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_hop_increment_i(cfg_hop_increment_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .channel_map_i      (channel_map_i),
    .instant_i          (instant_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .channel_o          (channel_o),
    .frequency_offset_o (frequency_offset_o),
    .event_count_o      (event_count_o),
    .map_empty_o        (map_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reset held from the start, released once and never asserted again
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  hop_cmd_t    cmd_q[$];        // beats waiting for the driver
  hop_result_t hops_due_q[$];   // predicted hops, oldest first

  int cmds_queued  = 0;
  int cmds_taken   = 0;
  int hops_checked = 0;
  int cfg_writes   = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;

  // Stimulus-side view of the event counter and phase, so that instants can
  // be aimed at counter values the block will actually reach
  logic [bledch_pkg::InstW-1:0] gen_count = '0;
  logic                         gen_check = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the hopper after reset
  // --------------------------------------------------------------------------
  logic [bledch_pkg::HopIncW-1:0] exp_hop_inc    = bledch_pkg::HopIncReset;
  logic [bledch_pkg::ChanW-1:0]   exp_unmapped   = '0;
  logic [bledch_pkg::MapW-1:0]    exp_map        = '0;
  logic [bledch_pkg::ChanW-1:0]   exp_used       = '0;
  logic [bledch_pkg::ChanW-1:0]   exp_remap [bledch_pkg::NumDataChannels];
  logic [bledch_pkg::MapW-1:0]    exp_pend_map   = '0;
  logic [bledch_pkg::InstW-1:0]   exp_pend_inst  = bledch_pkg::InstantReset;
  logic                           exp_pend_valid = 1'b0;
  logic [bledch_pkg::InstW-1:0]   exp_evt        = '0;
  logic                           exp_check      = 1'b0;

  // Map port is exactly NumDataChannels wide, so no bits need masking off
  task automatic load_active(input logic [bledch_pkg::MapW-1:0] m);
    exp_map  = m;
    exp_used = '0;
    for (int n = 0; n < bledch_pkg::NumDataChannels; n++) begin
      if (m[n]) begin
        exp_remap[exp_used] = bledch_pkg::ChanW'(n);
        exp_used++;
      end
    end
  endtask

  // One hop: step the unmapped channel, remap if unused, queue the result
  task automatic next_hop();
    int u;
    int f;
    hop_result_t r;
    u = (int'(exp_unmapped) + int'(exp_hop_inc)) % bledch_pkg::NumDataChannels;
    exp_unmapped = bledch_pkg::ChanW'(u);
    r.channel = '0;
    r.empty   = 1'b0;
    if (exp_map[u]) begin
      r.channel = bledch_pkg::ChanW'(u);
    end else if (exp_used == 0) begin
      r.empty = 1'b1;
    end else begin
      r.channel = exp_remap[u % int'(exp_used)];
    end
    if (r.channel <= bledch_pkg::LowBandLast) begin
      f = int'(bledch_pkg::FreqLowBase) + 2 * int'(r.channel);
    end else begin
      f = int'(bledch_pkg::FreqHighBase) + 2 * int'(r.channel);
    end
    r.freq  = bledch_pkg::FreqW'(f);
    r.count = exp_evt;
    hops_due_q.push_back(r);
  endtask

  task automatic advance_hopper(input hop_cmd_t c);
    logic [bledch_pkg::InstW-1:0] diff;
    case (c.op)
      bledch_pkg::OpStart: begin
        load_active(c.map);
        exp_unmapped   = '0;
        exp_evt        = '0;
        exp_pend_valid = 1'b0;
        exp_pend_map   = '0;
        exp_pend_inst  = bledch_pkg::InstantReset;
        exp_check      = 1'b0;
        next_hop();
      end
      bledch_pkg::OpEvent: begin
        if (!exp_check) begin
          exp_evt   = exp_evt + 16'd1;
          exp_check = 1'b1;
          next_hop();
        end else begin
          // check half: a held map lands only at its exact instant
          if (exp_pend_valid && exp_evt == exp_pend_inst) begin
            load_active(exp_pend_map);
            exp_pend_valid = 1'b0;
          end
          exp_check = 1'b0;
        end
      end
      bledch_pkg::OpUpdate: begin
        diff = c.inst - exp_evt;
        if (diff < bledch_pkg::InstantWindow) begin
          exp_pend_map   = c.map;
          exp_pend_inst  = c.inst;
          exp_pend_valid = 1'b1;
        end else begin
          // instant already passed: apply now, forget any held map
          load_active(c.map);
          exp_pend_valid = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [bledch_pkg::MapW-1:0] rand_map();
    logic [bledch_pkg::MapW-1:0] m;
    m = bledch_pkg::MapW'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = '1;
      2: m = bledch_pkg::MapW'(1) << $urandom_range(0, bledch_pkg::MapW - 1);
      3: m = (bledch_pkg::MapW'(1) << $urandom_range(0, bledch_pkg::MapW - 1))
           | (bledch_pkg::MapW'(1) << $urandom_range(0, bledch_pkg::MapW - 1));
      4: m = m & bledch_pkg::MapW'({$urandom, $urandom})
               & bledch_pkg::MapW'({$urandom, $urandom});
      5: m = m | bledch_pkg::MapW'({$urandom, $urandom});
      default: ;
    endcase
    return m;
  endfunction

  task automatic push_cmd(input logic [bledch_pkg::OpW-1:0] op,
                          input logic [bledch_pkg::MapW-1:0] map,
                          input logic [bledch_pkg::InstW-1:0] inst);
    hop_cmd_t c;
    c.op   = op;
    c.map  = map;
    c.inst = inst;
    cmd_q.push_back(c);
    cmds_queued++;
    if (op == bledch_pkg::OpStart) begin
      gen_count = '0;
      gen_check = 1'b0;
    end else if (op == bledch_pkg::OpEvent) begin
      if (!gen_check) gen_count = gen_count + 16'd1;
      gen_check = !gen_check;
    end
  endtask

  // Mostly connection events on a live map, with updates aimed just ahead of
  // the counter so that held maps really land; the rest is noise
  task automatic gen_random(input int n);
    int r;
    push_cmd(bledch_pkg::OpStart, rand_map(), bledch_pkg::InstW'($urandom));
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_cmd(bledch_pkg::OpStart, rand_map(), bledch_pkg::InstW'($urandom));
      end else if (r < 70) begin
        push_cmd(bledch_pkg::OpEvent, bledch_pkg::MapW'({$urandom, $urandom}),
                 bledch_pkg::InstW'($urandom));
      end else if (r < 84) begin
        push_cmd(bledch_pkg::OpUpdate, rand_map(),
                 gen_count + bledch_pkg::InstW'($urandom_range(0, 4)));
      end else if (r < 90) begin
        push_cmd(bledch_pkg::OpUpdate, rand_map(),
                 gen_count - bledch_pkg::InstW'($urandom_range(1, 40)));
      end else if (r < 95) begin
        push_cmd(bledch_pkg::OpUpdate, rand_map(), bledch_pkg::InstW'($urandom));
      end else begin
        push_cmd(OpUnused, bledch_pkg::MapW'({$urandom, $urandom}),
                 bledch_pkg::InstW'($urandom));
      end
    end
  endtask

  // Quiet means every beat taken, every hop seen and the rebuild window gone
  task automatic wait_drained();
    do @(posedge clk_i);
    while (cmds_taken != cmds_queued || hops_due_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_hop_increment(input logic [bledch_pkg::HopIncW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_hop_increment_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Command driver: one beat at a time from cmd_q, random gap after each
  // --------------------------------------------------------------------------
  int       gap_left  = 0;
  int       calm_left = 0;
  int       drv_gap;
  hop_cmd_t cmd_now;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) begin
        // beat still offered: hold valid and payload
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cmd_now = cmd_q.pop_front();
        in_valid_i    <= 1'b1;
        operation_i   <= cmd_now.op;
        channel_map_i <= cmd_now.map;
        instant_i     <= cmd_now.inst;
        // now and then a run of back-to-back beats
        if (calm_left != 0) begin
          calm_left--;
          drv_gap = 0;
        end else begin
          if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(8, 32);
          drv_gap = pick_gap();
        end
        gap_left <= drv_gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side back-pressure: ready windows alternate with stalls
  // --------------------------------------------------------------------------
  int ready_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ready_left == 0) begin
        out_ready_i <= !out_ready_i;
        if (out_ready_i) begin
          ready_left <= pick_gap();
        end else if ($urandom_range(0, 9) == 0) begin
          ready_left <= $urandom_range(100, 300);
        end else begin
          ready_left <= $urandom_range(1, 30);
        end
      end else begin
        ready_left <= ready_left - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: feeds the predictor from accepted beats, checks result beats
  // --------------------------------------------------------------------------
  hop_result_t want;
  hop_cmd_t    seen_cmd;

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        exp_hop_inc = cfg_hop_increment_i;
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        seen_cmd.op   = operation_i;
        seen_cmd.map  = channel_map_i;
        seen_cmd.inst = instant_i;
        advance_hopper(seen_cmd);
        cmds_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        if (hops_due_q.size() == 0) begin
          $display("%0t: unexpected hop beat: expected none, actual channel %0d count %0d",
                   $time, channel_o, event_count_o);
          fail_count++;
        end else begin
          want = hops_due_q.pop_front();
          check_field("channel", 32'(want.channel), 32'(channel_o));
          check_field("frequency_offset", 32'(want.freq), 32'(frequency_offset_o));
          check_field("event_count", 32'(want.count), 32'(event_count_o));
          check_field("map_empty", 32'(want.empty), 32'(map_empty_o));
          hops_checked++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with no handshake anywhere
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d hops outstanding",
                 $time, idle_cycles, hops_due_q.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // Directed beats at the reset hop increment
    // tick straight out of reset: empty map, so the hop is flagged empty
    push_cmd(bledch_pkg::OpEvent, bledch_pkg::MapW'({$urandom, $urandom}),
             bledch_pkg::InstW'($urandom));
    push_cmd(bledch_pkg::OpEvent, '0, '0);                  // check half
    push_cmd(OpUnused, '1, '1);                             // ignored code
    push_cmd(bledch_pkg::OpStart, '1, 16'hFFFF);            // every channel used
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpStart, '0, '0);                  // empty map
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    // top channel only
    push_cmd(bledch_pkg::OpStart, bledch_pkg::MapW'(1) << (bledch_pkg::MapW - 1), '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    // low/high band boundary channels only
    push_cmd(bledch_pkg::OpStart,
             (bledch_pkg::MapW'(1) << 10) | (bledch_pkg::MapW'(1) << 11), '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    // instant just behind the counter: applies at once
    push_cmd(bledch_pkg::OpUpdate,
             bledch_pkg::MapW'(1) | (bledch_pkg::MapW'(1) << (bledch_pkg::MapW - 1)),
             gen_count - 16'd1);
    // last instant still inside the window: held
    push_cmd(bledch_pkg::OpUpdate, '1, gen_count + 16'd32766);
    // first instant outside the window: applies at once, drops the held map
    push_cmd(bledch_pkg::OpUpdate, bledch_pkg::MapW'(64'h0_0000_1C00),
             gen_count + 16'd32767);
    // held until the next hop's check half
    push_cmd(bledch_pkg::OpUpdate, bledch_pkg::MapW'(64'h0A_AAAA_AAAA),
             gen_count + 16'd1);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    // instant equals the counter with a check half next: lands on it
    push_cmd(bledch_pkg::OpUpdate, bledch_pkg::MapW'(1) << 5, gen_count);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    // instant equals the counter, again with a check half next: lands on it
    push_cmd(bledch_pkg::OpUpdate, '0, gen_count);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    push_cmd(bledch_pkg::OpEvent, '0, '0);
    wait_drained();

    // Random phases across hop increments, extremes included
    set_hop_increment('0);
    gen_random(90);
    wait_drained();

    set_hop_increment('1);
    gen_random(100);
    wait_drained();

    set_hop_increment(bledch_pkg::HopIncW'(1));
    gen_random(100);
    wait_drained();

    set_hop_increment(bledch_pkg::HopIncW'($urandom));
    gen_random(110);
    wait_drained();

    set_hop_increment(bledch_pkg::HopIncW'($urandom_range(2, 30)));
    gen_random(90);
    wait_drained();

    $display("Covered %0d command beats and %0d hop beats over %0d hop-increment settings,",
             cmds_taken, hops_checked, cfg_writes + 1);
    $display("with map loads, held and immediate updates, and result-side stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
